// ===== rtl/anp_pkg.sv =====
// ----------------------------------------------------------------------------
// anp_pkg - shared types and constants for the ASCII number parser
// Parse phases, body shape codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package anp_pkg;

	localparam int unsigned ACC_W   = 33;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESULT_KIND = 2'd2;

	// mark modes; the unused code behaves as none
	localparam logic [1:0] MARK_NONE   = 2'd0;
	localparam logic [1:0] MARK_SUFFIX = 2'd1;
	localparam logic [1:0] MARK_PREFIX = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_U8  = 3'd0;
	localparam logic [2:0] KIND_U16 = 3'd1;
	localparam logic [2:0] KIND_U32 = 3'd2;
	localparam logic [2:0] KIND_S8  = 3'd3;
	localparam logic [2:0] KIND_S16 = 3'd4;
	localparam logic [2:0] KIND_S32 = 3'd5;

	// accumulator selection, also the bit of its overflow flag
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UH    = 8'h48;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LH    = 8'h68;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

	localparam logic [ACC_W-1:0] ACC_LIMIT = 33'h1_0000_0000;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SIGN,
		PH_BODY,
		PH_TRAIL,
		PH_FAIL
	} phase_t;

	// shape of the body seen so far
	typedef enum logic [2:0] {
		TR_EMPTY,
		TR_ZERO,
		TR_X,
		TR_XDIG,
		TR_DIG,
		TR_DIG0,
		TR_HSUF,
		TR_BAD
	} shape_t;

endpackage

// ===== rtl/anp_in_if.sv =====
// ----------------------------------------------------------------------------
// anp_in_if - character channel
// One text character or an end mark per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface anp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_end;

	modport source (output valid, output char_code, output is_end, input ready);
	modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

// ===== rtl/anp_out_if.sv =====
// ----------------------------------------------------------------------------
// anp_out_if - result channel
// Parsed value and pass flag per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface anp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        ok;

	modport source (output valid, output value, output ok, input ready);
	modport sink   (input valid, input value, input ok, output ready);
endinterface

// ===== rtl/ascii_number_parser_unit.sv =====
// Result path: a closing end word passes the input register, then the result register.
// Throughput: one word per cycle, but for the end-word stall below; the parse
// state (three constant-radix accumulators and the shape tracker) is updated per word.
// An end word waits in the input register only while an earlier result is
// still held unread in the result register.
// Reset (arst_n low, async): parse state cleared, registers to none/dec/u32.
// ----------------------------------------------------------------------------
// ascii_number_parser_unit - streaming text to integer converter
// Reads characters one word at a time and on the end word produces the
// value and a pass flag, with strtoul/strtol style rules and range check.
// ----------------------------------------------------------------------------
module ascii_number_parser_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	anp_in_if.sink                         char_ch,
	anp_out_if.source                      res_ch,
	input  logic                           cfg_we,
	input  logic [anp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [anp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import anp_pkg::*;

	// configuration
	logic [1:0] mark_mode_q;
	logic       base_select_q;
	logic [2:0] result_kind_q;

	// input register
	logic              v_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;

	// parse state
	phase_t           phase_q, phase_d;
	shape_t           shape_q, shape_d;
	logic [ACC_W-1:0] dec_q, hex_q, oct_q;
	logic [ACC_W-1:0] dec_d, hex_d, oct_d;
	logic [2:0]       ovf_q, ovf_d;
	logic [1:0]       fail_q, fail_d;
	logic             neg_q, neg_d;

	// result register
	logic               out_v_q;
	logic [VALUE_W-1:0] value_q;
	logic               ok_q;

	logic in_fire, s1_adv, out_free;

	// character classes
	logic       is_sp, is_sign, is_dig, is_oct, is_hex, is_x, is_h, take_body;
	logic [3:0] hval;

	// end-of-text evaluation
	logic               fin_ok, sel_ok, rng_ok, hex_plain;
	logic [1:0]         which;
	logic [ACC_W-1:0]   mag;
	logic [VALUE_W-1:0] fin_val;

	// ------------------------------------------------------------------
	// Handshake: s1 advances unless it holds an end word facing a full,
	// unread result register.
	// ------------------------------------------------------------------
	assign out_free = !out_v_q || res_ch.ready;
	assign s1_adv   = v_s1 && (!end_s1 || out_free);
	assign char_ch.ready = !v_s1 || s1_adv;
	assign in_fire  = char_ch.valid && char_ch.ready;

	assign res_ch.valid = out_v_q;
	assign res_ch.value = value_q;
	assign res_ch.ok    = ok_q;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_mode_q   <= MARK_NONE;
			base_select_q <= 1'b0;
			result_kind_q <= KIND_U32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MARK_MODE:   mark_mode_q   <= cfg_wdata[1:0];
				CFG_BASE_SELECT: base_select_q <= cfg_wdata[0];
				CFG_RESULT_KIND: result_kind_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			v_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= char_ch.char_code;
			end_s1  <= char_ch.is_end;
		end
	end

	// ------------------------------------------------------------------
	// Character decode
	// ------------------------------------------------------------------
	always_comb begin
		is_sp   = (char_s1 == CH_SPACE) || (char_s1 >= CH_TAB && char_s1 <= CH_CR);
		is_sign = (char_s1 == CH_PLUS) || (char_s1 == CH_MINUS);
		is_dig  = (char_s1 >= CH_0) && (char_s1 <= CH_9);
		is_oct  = (char_s1 >= CH_0) && (char_s1 <= CH_7);
		is_x    = (char_s1 == CH_LX) || (char_s1 == CH_UX);
		is_h    = (char_s1 == CH_LH) || (char_s1 == CH_UH);
		is_hex  = 1'b1;
		hval    = '0;
		if (is_dig) begin
			hval = char_s1[3:0];
		end else if (char_s1 >= CH_LA && char_s1 <= CH_LF) begin
			hval = 4'(char_s1 - CH_LA + 8'd10);
		end else if (char_s1 >= CH_UA && char_s1 <= CH_UF) begin
			hval = 4'(char_s1 - CH_UA + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Phase sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		phase_d = phase_q;
		if (end_s1) begin
			phase_d = PH_LEAD;
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					if (is_sign)     phase_d = PH_SIGN;
					else if (!is_sp) phase_d = PH_BODY;
				end
				PH_SIGN: begin
					phase_d = (is_sp || is_sign) ? PH_FAIL : PH_BODY;
				end
				PH_BODY: begin
					if (is_sp) phase_d = PH_TRAIL;
				end
				PH_TRAIL: begin
					if (!is_sp) phase_d = PH_FAIL;
				end
				default: phase_d = PH_FAIL;
			endcase
		end
	end

	// Phase sequencer: outputs (body character strobe)
	always_comb begin
		unique case (phase_q)
			PH_LEAD: take_body = !is_sp && !is_sign;
			PH_SIGN: take_body = !is_sp && !is_sign;
			PH_BODY: take_body = !is_sp;
			default: take_body = 1'b0;
		endcase
		take_body = take_body && !end_s1;
	end

	// ------------------------------------------------------------------
	// Accumulators: constant-radix multiply-add, saturating at 2^32
	// ------------------------------------------------------------------
	function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W+3:0] n);
		sat_acc = (n > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : n[ACC_W-1:0];
	endfunction

	logic [ACC_W+3:0] dec_n, hex_n, oct_n;

	always_comb begin
		dec_n = ({4'd0, dec_q} << 3) + ({4'd0, dec_q} << 1) + {33'd0, hval};
		hex_n = ({4'd0, hex_q} << 4) + {33'd0, hval};
		oct_n = ({4'd0, oct_q} << 3) + {33'd0, hval};

		dec_d  = dec_q;
		hex_d  = hex_q;
		oct_d  = oct_q;
		ovf_d  = ovf_q;
		fail_d = fail_q;
		neg_d  = neg_q || (phase_q == PH_LEAD && char_s1 == CH_MINUS);

		if (take_body) begin
			if (is_dig) begin
				dec_d = sat_acc(dec_n);
				if (dec_n > {4'd0, ACC_LIMIT}) ovf_d[BASE_DEC] = 1'b1;
			end else begin
				fail_d[0] = 1'b1;
			end
			if (is_hex) begin
				hex_d = sat_acc(hex_n);
				if (hex_n > {4'd0, ACC_LIMIT}) ovf_d[BASE_HEX] = 1'b1;
			end
			if (is_oct) begin
				oct_d = sat_acc(oct_n);
				if (oct_n > {4'd0, ACC_LIMIT}) ovf_d[BASE_OCT] = 1'b1;
			end else begin
				fail_d[1] = 1'b1;
			end
		end
	end

	// body shape tracker
	always_comb begin
		shape_d = shape_q;
		if (take_body) begin
			unique case (shape_q) inside
				TR_EMPTY: begin
					if (char_s1 == CH_0) shape_d = TR_ZERO;
					else                 shape_d = is_hex ? TR_DIG : TR_BAD;
				end
				TR_ZERO: begin
					if (is_x)        shape_d = TR_X;
					else if (is_hex) shape_d = TR_DIG0;
					else             shape_d = is_h ? TR_HSUF : TR_BAD;
				end
				TR_X: shape_d = is_hex ? TR_XDIG : TR_BAD;
				TR_XDIG, TR_DIG, TR_DIG0: begin
					if (!is_hex) shape_d = is_h ? TR_HSUF : TR_BAD;
				end
				default: shape_d = TR_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			shape_q <= TR_EMPTY;
			dec_q   <= '0;
			hex_q   <= '0;
			oct_q   <= '0;
			ovf_q   <= '0;
			fail_q  <= '0;
			neg_q   <= 1'b0;
		end else if (s1_adv) begin
			if (end_s1) begin
				// text closed: back to the reset parse state
				phase_q <= PH_LEAD;
				shape_q <= TR_EMPTY;
				dec_q   <= '0;
				hex_q   <= '0;
				oct_q   <= '0;
				ovf_q   <= '0;
				fail_q  <= '0;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				shape_q <= shape_d;
				dec_q   <= dec_d;
				hex_q   <= hex_d;
				oct_q   <= oct_d;
				ovf_q   <= ovf_d;
				fail_q  <= fail_d;
				neg_q   <= neg_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// End of text: pick the base, then range check for the result kind
	// ------------------------------------------------------------------
	always_comb begin
		hex_plain = (shape_q == TR_ZERO) || (shape_q == TR_XDIG) ||
			(shape_q == TR_DIG) || (shape_q == TR_DIG0);
		sel_ok = 1'b1;
		which  = BASE_DEC;
		unique case (mark_mode_q)
			MARK_SUFFIX: begin
				if (shape_q == TR_HSUF) which  = BASE_HEX;
				else if (fail_q[0])     sel_ok = 1'b0;
			end
			MARK_PREFIX: begin
				if (shape_q == TR_XDIG) begin
					which = BASE_HEX;
				end else if ((shape_q == TR_ZERO || shape_q == TR_DIG0) && !fail_q[1]) begin
					which = BASE_OCT;
				end else if (!(shape_q == TR_DIG && !fail_q[0])) begin
					sel_ok = 1'b0;
				end
			end
			default: begin
				if (base_select_q) begin
					which  = BASE_HEX;
					sel_ok = hex_plain;
				end else begin
					sel_ok = !fail_q[0];
				end
			end
		endcase

		unique case (which)
			BASE_HEX: mag = hex_q;
			BASE_OCT: mag = oct_q;
			default:  mag = dec_q;
		endcase

		fin_val = mag[VALUE_W-1:0];
		unique case (result_kind_q)
			KIND_U8:  rng_ok = !neg_q && mag <= 33'h0_0000_00ff;
			KIND_U16: rng_ok = !neg_q && mag <= 33'h0_0000_ffff;
			KIND_U32: rng_ok = !neg_q && !mag[ACC_W-1];
			KIND_S8:  rng_ok = neg_q ? (mag <= 33'h0_0000_0080) : (mag < 33'h0_0000_0080);
			KIND_S16: rng_ok = neg_q ? (mag <= 33'h0_0000_8000) : (mag < 33'h0_0000_8000);
			KIND_S32: rng_ok = neg_q ? (mag <= 33'h0_8000_0000) : (mag < 33'h0_8000_0000);
			default:  rng_ok = 1'b0;
		endcase
		if (neg_q) fin_val = VALUE_W'(0) - mag[VALUE_W-1:0];

		fin_ok = (phase_q == PH_BODY || phase_q == PH_TRAIL) && sel_ok &&
			!ovf_q[which] && rng_ok;
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s1_adv && end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && end_s1) begin
			value_q <= fin_ok ? fin_val : '0;
			ok_q    <= fin_ok;
		end
	end

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !ok_q |-> value_q == '0)
		else $error("failed result carries nonzero value");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q <= ACC_LIMIT && hex_q <= ACC_LIMIT && oct_q <= ACC_LIMIT)
		else $error("accumulator beyond saturation limit");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && end_s1 |=> phase_q == PH_LEAD && shape_q == TR_EMPTY && !neg_q)
		else $error("parse state not cleared after end word");

	a_neg_phase: assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> phase_q != PH_LEAD)
		else $error("minus flag set in leading space phase");

	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && end_s1 && out_v_q && !res_ch.ready |=> v_s1 && end_s1)
		else $error("end word dropped while result register full");
`endif

endmodule
